>>> rtl/core/assert_macros.svh
// Assertion helpers for the buffer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset
`define TPLB_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("tplb assertion failed");

// Same-cycle implication, checked outside reset
`define TPLB_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("tplb implication failed");

`endif

>>> rtl/core/tplb_pkg.sv
package tplb_pkg;

    // fixed field widths
    localparam int KEY_W      = 64;
    localparam int THR_W      = 16;
    localparam int CAP_W      = 5;
    localparam int CNT_OUT_W  = 16;
    localparam int OCC_W      = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 4'd1;

    // register reset values
    localparam logic [THR_W-1:0] THR_RESET = 16'd3;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_SHIFT,
        ST_FRONT
    } tplb_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic search;
        logic decide;
        logic shift;
        logic front;
    } tplb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic search_done;
        logic shift_done;
    } tplb_sts_t;

endpackage

>>> rtl/core/tplb_ctrl.sv
module tplb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                operation,
    input  tplb_pkg::tplb_sts_t sts,
    output tplb_pkg::tplb_cmd_t cmd,
    output logic                busy
);
    import tplb_pkg::*;

    tplb_state_t state_reg;
    tplb_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.search_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = ST_FRONT;
                end
            end
            ST_FRONT:
            begin
                cmd.front  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> rtl/core/tplb_datapath.sv
module tplb_datapath #(
    parameter int DEPTH      = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tplb_pkg::tplb_cmd_t                 cmd,
    output tplb_pkg::tplb_sts_t                 sts,
    input  logic [tplb_pkg::KEY_W-1:0]          key,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tplb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tplb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                done,
    output logic                                hit,
    output logic [tplb_pkg::CNT_OUT_W-1:0]      count_after,
    output logic                                promoted,
    output logic                                evicted,
    output logic [tplb_pkg::KEY_W-1:0]          evicted_key,
    output logic [tplb_pkg::OCC_W-1:0]          occupancy
);
    import tplb_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENT_W  = KEY_W + COUNT_BITS;
    localparam int CW     = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam int TW     = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // entry memory: key in the upper bits, hit count in the lower
    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rdata_reg;

    // configuration
    logic [THR_W-1:0] thr_reg;
    logic [CAP_W-1:0] cap_reg;

    // control state
    logic [FILL_W-1:0] fill_reg;
    logic              done_reg;

    // working registers of the current request
    logic [KEY_W-1:0]      key_reg;
    logic [FILL_W-1:0]     cnt_reg;
    logic                  pend_reg;
    logic [IDX_W-1:0]      pend_addr_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      found_reg;
    logic [COUNT_BITS-1:0] old_cnt_reg;
    logic [KEY_W-1:0]      tail_key_reg;
    logic                  promo_reg;
    logic                  evict_reg;
    logic                  front_zero_reg;
    logic [COUNT_BITS-1:0] new_cnt_reg;
    logic [FILL_W-1:0]     fill_new_reg;

    // result registers
    logic                  res_hit_reg;
    logic [CNT_OUT_W-1:0]  res_cnt_reg;
    logic                  res_promo_reg;
    logic                  res_evict_reg;
    logic [KEY_W-1:0]      res_ev_key_reg;
    logic [OCC_W-1:0]      res_occ_reg;

    // combinational helpers
    logic                  more;
    logic                  match;
    logic                  issue_search;
    logic                  issue_shift;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [FILL_W-1:0]     cnt_dec;
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [ENT_W-1:0]      wdata;
    logic [KEY_W-1:0]      rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  old_max;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  promo_d;
    logic [CW-1:0]         cap_ext;
    logic [CW-1:0]         cap_eff;
    logic                  evict_d;
    logic [FILL_W-1:0]     nprime;

    assign cfg_ready = 1'b1;

    assign rd_key = rdata_reg[ENT_W-1:COUNT_BITS];
    assign rd_cnt = rdata_reg[COUNT_BITS-1:0];

    // search walks front to tail; the compare uses the registered read data, in the cycle after the read
    assign more         = (cnt_reg < fill_reg);
    assign match        = pend_reg && (rd_key == key_reg);
    assign issue_search = cmd.search && more && !match;
    assign cnt_dec      = cnt_reg - 1'b1;
    assign issue_shift  = cmd.shift && (cnt_reg != '0);

    assign sts.search_done = cmd.search && (match || !more);
    assign sts.shift_done  = cmd.shift && (cnt_reg == '0);

    assign rd_en   = issue_search || issue_shift;
    assign rd_addr = cmd.search ? cnt_reg[IDX_W-1:0] : cnt_dec[IDX_W-1:0];

    // shift writes each entry one place toward the tail, front write last
    assign we    = (cmd.shift && pend_reg) || cmd.front;
    assign waddr = cmd.shift ? IDX_W'(pend_addr_reg + 1'b1)
                             : (front_zero_reg ? '0 : found_reg);
    assign wdata = cmd.shift ? rdata_reg : {key_reg, new_cnt_reg};

    // hit count update and promotion test
    assign old_max = (old_cnt_reg == CNT_MAX);
    assign cnt_inc = old_max ? old_cnt_reg : old_cnt_reg + 1'b1;
    assign promo_d = hit_reg && !old_max && (TW'(old_cnt_reg) == TW'(thr_reg));

    // effective capacity, clamped to 1..DEPTH
    assign cap_ext = CW'(cap_reg);
    always_comb
    begin
        priority if (cap_ext == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (cap_ext > CW'(DEPTH))
        begin
            cap_eff = CW'(DEPTH);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign evict_d = !hit_reg && (CW'(fill_reg) >= cap_eff);
    assign nprime  = evict_d ? fill_reg - 1'b1 : fill_reg;

    // entry memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:
                begin
                    thr_reg <= cfg_data[THR_W-1:0];
                end
                CFG_CAPACITY:
                begin
                    cap_reg <= cfg_data[CAP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // fill level and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.front || cmd.clear;
            if (cmd.clear)
            begin
                fill_reg <= '0;
            end
            else if (cmd.front)
            begin
                fill_reg <= fill_new_reg;
            end
        end
    end

    // request working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end

        if (cmd.search)
        begin
            pend_reg      <= issue_search;
            pend_addr_reg <= cnt_reg[IDX_W-1:0];
            if (issue_search)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (sts.search_done)
            begin
                hit_reg      <= match;
                found_reg    <= pend_addr_reg;
                old_cnt_reg  <= rd_cnt;
                tail_key_reg <= rd_key;
            end
        end

        if (cmd.decide)
        begin
            pend_reg       <= 1'b0;
            promo_reg      <= promo_d;
            evict_reg      <= evict_d;
            front_zero_reg <= !hit_reg || promo_d;
            if (hit_reg)
            begin
                new_cnt_reg  <= cnt_inc;
                fill_new_reg <= fill_reg;
                cnt_reg      <= promo_d ? FILL_W'(found_reg) : '0;
            end
            else
            begin
                new_cnt_reg  <= COUNT_BITS'(1);
                fill_new_reg <= nprime + 1'b1;
                cnt_reg      <= nprime;
            end
        end

        if (cmd.shift)
        begin
            pend_reg      <= issue_shift;
            pend_addr_reg <= cnt_dec[IDX_W-1:0];
            if (issue_shift)
            begin
                cnt_reg <= cnt_dec;
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            res_hit_reg    <= 1'b0;
            res_cnt_reg    <= '0;
            res_promo_reg  <= 1'b0;
            res_evict_reg  <= 1'b0;
            res_ev_key_reg <= '0;
            res_occ_reg    <= '0;
        end
        else if (cmd.front)
        begin
            res_hit_reg    <= hit_reg;
            res_cnt_reg    <= CNT_OUT_W'(new_cnt_reg);
            res_promo_reg  <= promo_reg;
            res_evict_reg  <= evict_reg;
            res_ev_key_reg <= evict_reg ? tail_key_reg : '0;
            res_occ_reg    <= OCC_W'(fill_new_reg);
        end
    end

    assign done        = done_reg;
    assign hit         = res_hit_reg;
    assign count_after = res_cnt_reg;
    assign promoted    = res_promo_reg;
    assign evicted     = res_evict_reg;
    assign evicted_key = res_ev_key_reg;
    assign occupancy   = res_occ_reg;

endmodule

>>> rtl/core/threshold_promoted_lru_buffer.sv
// Channel    | Direction | Handshake                        | Payload
// request    | in        | start, accepted when busy is low | operation, key
// result     | out       | done, one-cycle strobe           | hit, count_after, promoted,
//            |           |                                  | evicted, evicted_key, occupancy
// config     | in        | cfg_valid / cfg_ready            | cfg_index, cfg_data
//
// A clear never raises busy; done follows in the next cycle.
// An access holds busy through the search, decide, shift and front states: the entry
// memory is read front to tail for the search and back for the shift.
// done rises in the cycle busy falls.
// The result strobe cannot be held off; new requests wait while busy is high.
// rst_n (async, active low) empties the buffer and restores the config registers, not entries.
`include "assert_macros.svh"

module threshold_promoted_lru_buffer #(
    parameter int DEPTH      = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic [tplb_pkg::KEY_W-1:0]          key,
    output logic                                done,
    output logic                                hit,
    output logic [tplb_pkg::CNT_OUT_W-1:0]      count_after,
    output logic                                promoted,
    output logic                                evicted,
    output logic [tplb_pkg::KEY_W-1:0]          evicted_key,
    output logic [tplb_pkg::OCC_W-1:0]          occupancy,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tplb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tplb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tplb_pkg::*;

    tplb_cmd_t cmd;
    tplb_sts_t sts;

    // sequencer
    tplb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    // entry memory, search and shift datapath
    tplb_datapath #(
        .DEPTH      (DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .key         (key),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .hit         (hit),
        .count_after (count_after),
        .promoted    (promoted),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .occupancy   (occupancy)
    );

    // a result only follows an accepted clear or the end of an access
    `TPLB_ASSERT_IMPLY(a_done_source, clk, rst_n, done, $past(start || busy))

    // an access always ends with its result strobe
    `TPLB_ASSERT_IMPLY(a_end_has_result, clk, rst_n, $fell(busy), done)

    // promotion only on a hit, eviction only on a miss
    `TPLB_ASSERT(a_result_flags, clk, rst_n, !done || (!(promoted && !hit) && !(evicted && hit)))

endmodule
